[hw/rtl/stereo_windowed_rms_meter_defines.svh]
// assertion macros for the stereo windowed rms meter
`ifndef STEREO_WINDOWED_RMS_METER_DEFINES_SVH
`define STEREO_WINDOWED_RMS_METER_DEFINES_SVH

// checked while out of reset
`define SWRM_ASSERT(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (prop)) \
		else $error("swrm port check failed");

// checked at every edge, reset included
`define SWRM_ASSERT_ALWAYS(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) (prop)) \
		else $error("swrm port check failed during reset");

`endif

[hw/rtl/swrm_pkg.sv]
// shared types and constants of the stereo windowed rms meter
package swrm_pkg;

	localparam int WIN_W   = 16;
	localparam int LEVEL_W = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACCUM,
		ST_DIV,
		ST_SQRT_INIT,
		ST_SQRT,
		ST_LEVEL,
		ST_OUT
	} swrm_state_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_ADD,
		ACC_SWAP,
		ACC_CLOSE
	} swrm_acc_t;

	typedef struct packed {
		logic      load;
		logic      sq_step;
		swrm_acc_t acc;
		logic      div_step;
		logic      sqrt_init;
		logic      sqrt_step;
		logic      level_load;
	} swrm_ctrl_t;

endpackage

[hw/rtl/swrm_sample_if.sv]
// input channel carrying one stereo sample pair per item
interface swrm_sample_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

[hw/rtl/swrm_level_if.sv]
// output channel carrying the levels of one item
interface swrm_level_if import swrm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] volume;
	logic [LEVEL_W-1:0] left_level;
	logic [LEVEL_W-1:0] right_level;
	logic               window_done;

	modport source (output valid, output volume, output left_level, output right_level,
		output window_done, input ready);
	modport sink (input valid, input volume, input left_level, input right_level,
		input window_done, output ready);
endinterface

[hw/rtl/swrm_lane.sv]
// one channel: serial square, sum of squares, serial divide and serial square root
module swrm_lane import swrm_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swrm_ctrl_t                    ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [WIN_W-1:0]              win,
	output logic [LEVEL_W-1:0]            level
);

	localparam int PROD_W = 2 * SAMPLE_BITS;
	localparam int SUM_W  = PROD_W + COUNT_BITS - 1;
	localparam int ROOT_W = (SUM_W + 1) / 2;
	localparam int RAD_W  = 2 * ROOT_W;

	logic [SAMPLE_BITS-1:0] sample_u;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SAMPLE_BITS:0]   part_sum;
	logic [SUM_W-1:0]       prod_ext;
	logic [WIN_W:0]         div_trial;
	logic [WIN_W:0]         div_diff;
	logic                   div_ge;
	logic [ROOT_W+2:0]      sq_t;
	logic [ROOT_W+2:0]      sq_trial;
	logic [ROOT_W+2:0]      sq_diff;
	logic                   sq_ge;

	logic [SAMPLE_BITS-1:0] mcand_q;
	logic [PROD_W-1:0]      prod_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SUM_W-1:0]       div_q;
	logic [WIN_W-1:0]       rem_q;
	logic [RAD_W-1:0]       rad_q;
	logic [ROOT_W:0]        srem_q;
	logic [ROOT_W-1:0]      root_q;
	logic [LEVEL_W-1:0]     level_q;

	assign sample_u = sample;
	assign mag      = sample_u[SAMPLE_BITS-1] ? (~sample_u + 1'b1) : sample_u;
	assign part_sum = {1'b0, prod_q[PROD_W-1:SAMPLE_BITS]}
		+ (prod_q[0] ? {1'b0, mcand_q} : '0);
	assign prod_ext = SUM_W'(prod_q);

	assign div_trial = {rem_q, div_q[SUM_W-1]};
	assign div_ge    = div_trial >= {1'b0, win};
	assign div_diff  = div_trial - {1'b0, win};

	assign sq_t     = {srem_q, rad_q[RAD_W-1 -: 2]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign sq_ge    = sq_t >= sq_trial;
	assign sq_diff  = sq_t - sq_trial;

	assign level = level_q;

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			level_q <= '0;
		end else begin
			unique case (ctrl.acc)
				ACC_NONE:  sum_q <= sum_q;
				ACC_ADD:   sum_q <= sum_q + prod_ext;
				ACC_SWAP:  sum_q <= prod_ext;
				ACC_CLOSE: sum_q <= '0;
			endcase
			if (ctrl.level_load) begin
				level_q <= LEVEL_W'(root_q);
			end
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mcand_q <= mag;
			prod_q  <= {{SAMPLE_BITS{1'b0}}, mag};
		end else if (ctrl.sq_step) begin
			prod_q <= {part_sum, prod_q[SAMPLE_BITS-1:1]};
		end

		if (ctrl.acc == ACC_SWAP) begin
			div_q <= sum_q;
			rem_q <= '0;
		end else if (ctrl.acc == ACC_CLOSE) begin
			div_q <= sum_q + prod_ext;
			rem_q <= '0;
		end else if (ctrl.div_step) begin
			div_q <= {div_q[SUM_W-2:0], div_ge};
			rem_q <= div_ge ? div_diff[WIN_W-1:0] : div_trial[WIN_W-1:0];
		end

		if (ctrl.sqrt_init) begin
			rad_q  <= RAD_W'(div_q);
			srem_q <= '0;
			root_q <= '0;
		end else if (ctrl.sqrt_step) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			srem_q <= sq_ge ? sq_diff[ROOT_W:0] : sq_t[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], sq_ge};
		end
	end

endmodule

[hw/rtl/stereo_windowed_rms_meter.sv]
// top level of the stereo windowed rms meter
// The samples channel takes one stereo pair per item (valid/ready, accepted when both
// are high). The levels channel returns one item per input item: both channel
// levels, their maximum and a flag that marks the item that closed a window.
// window_length is written through cfg_we/cfg_wdata; the user must write it only while the
// block is idle, as the block itself does not enforce this. A value of 0 acts as 1.
// Each channel squares its sample one multiplier bit per cycle. Closing a window runs a
// restoring divide at one quotient bit per cycle over the 2*SAMPLE_BITS + COUNT_BITS - 1
// bit sum, then a square root at one root bit per cycle. Both channels run side by side.
// One item is in work at a time; the next is accepted the cycle after the result
// enters the output register, so the rate is set by the serial square, divide and
// root units.
// Reset clears the sums, the sample count and the levels, sets window_length to 1 and
// empties the output register. A stalled receiver holds the result in the output
// register; a following item is still processed and waits for the register to free.
module stereo_windowed_rms_meter import swrm_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	swrm_sample_if.sink        samples,
	swrm_level_if.source       levels,
	input  logic               cfg_we,
	input  logic [WIN_W-1:0]   cfg_wdata
);

	localparam int SUM_W  = 2 * SAMPLE_BITS + COUNT_BITS - 1;
	localparam int ROOT_W = (SUM_W + 1) / 2;
	localparam int CNT_W  = $clog2(SUM_W + 1);
	localparam int CMP_W  = ((COUNT_BITS > WIN_W) ? COUNT_BITS : WIN_W) + 1;

	swrm_state_t          state_q, state_d;
	swrm_ctrl_t           ctrl;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [COUNT_BITS-1:0] count_q, count_d;
	logic                 done_q, done_d;
	logic [WIN_W-1:0]     window_q;
	logic [WIN_W-1:0]     win_eff;
	logic [CMP_W-1:0]     count_ext;
	logic [CMP_W-1:0]     win_ext;
	logic                 out_load;
	logic [LEVEL_W-1:0]   left_level;
	logic [LEVEL_W-1:0]   right_level;

	logic                 out_valid_q;
	logic [LEVEL_W-1:0]   out_volume_q;
	logic [LEVEL_W-1:0]   out_left_q;
	logic [LEVEL_W-1:0]   out_right_q;
	logic                 out_done_q;

	assign win_eff   = (window_q == '0) ? WIN_W'(1) : window_q;
	assign count_ext = CMP_W'(count_q);
	assign win_ext   = CMP_W'(win_eff);

	swrm_lane #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (samples.left_sample),
		.win    (win_eff),
		.level  (left_level)
	);

	swrm_lane #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (samples.right_sample),
		.win    (win_eff),
		.level  (right_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			count_q     <= '0;
			done_q      <= 1'b0;
			window_q    <= WIN_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			count_q <= count_d;
			done_q  <= done_d;
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (levels.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_volume_q <= (left_level > right_level) ? left_level : right_level;
			out_left_q   <= left_level;
			out_right_q  <= right_level;
			out_done_q   <= done_q;
		end
	end

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		count_d       = count_q;
		done_d        = done_q;
		ctrl          = '0;
		samples.ready = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					ctrl.load = 1'b1;
					cnt_d     = CNT_W'(SAMPLE_BITS - 1);
					state_d   = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				ctrl.sq_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_ACCUM;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_ACCUM: begin
				priority if (count_ext >= win_ext) begin
					// window was shrunk: close old sums, sample opens the new window
					ctrl.acc = ACC_SWAP;
					count_d  = COUNT_BITS'(1);
					done_d   = 1'b1;
					cnt_d    = CNT_W'(SUM_W - 1);
					state_d  = ST_DIV;
				end else if (count_ext + CMP_W'(1) == win_ext) begin
					ctrl.acc = ACC_CLOSE;
					count_d  = '0;
					done_d   = 1'b1;
					cnt_d    = CNT_W'(SUM_W - 1);
					state_d  = ST_DIV;
				end else begin
					ctrl.acc = ACC_ADD;
					count_d  = count_q + 1'b1;
					done_d   = 1'b0;
					state_d  = ST_OUT;
				end
			end
			ST_DIV: begin
				ctrl.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_SQRT_INIT;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_SQRT_INIT: begin
				ctrl.sqrt_init = 1'b1;
				cnt_d          = CNT_W'(ROOT_W - 1);
				state_d        = ST_SQRT;
			end
			ST_SQRT: begin
				ctrl.sqrt_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_LEVEL;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_LEVEL: begin
				ctrl.level_load = 1'b1;
				state_d         = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || levels.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	assign levels.valid       = out_valid_q;
	assign levels.volume      = out_volume_q;
	assign levels.left_level  = out_left_q;
	assign levels.right_level = out_right_q;
	assign levels.window_done = out_done_q;

endmodule

[hw/rtl/swrm_port_checker.sv]
// port checker for the stereo windowed rms meter and its bind
`include "stereo_windowed_rms_meter_defines.svh"

module swrm_port_checker import swrm_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [LEVEL_W-1:0] volume,
	input logic [LEVEL_W-1:0] left_level,
	input logic [LEVEL_W-1:0] right_level,
	input logic               window_done
);

	`SWRM_ASSERT_ALWAYS(a_reset_empty, clk, (!arst_n) |-> (!out_valid))

	`SWRM_ASSERT(a_one_item_in_work, clk, arst_n, (in_valid && in_ready) |=> (!in_ready))

	`SWRM_ASSERT(a_volume_is_max, clk, arst_n, out_valid |-> (volume == ((left_level > right_level) ? left_level : right_level)))

	`SWRM_ASSERT(a_stalled_item_holds, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable({volume, left_level, right_level, window_done})))

endmodule

bind stereo_windowed_rms_meter swrm_port_checker u_port_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (levels.valid),
	.out_ready   (levels.ready),
	.volume      (levels.volume),
	.left_level  (levels.left_level),
	.right_level (levels.right_level),
	.window_done (levels.window_done)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// testbench for the stereo windowed rms meter: directed and random sample pairs checked against a level predictor
module tb_top;
	import swrm_pkg::*;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 16;
	localparam int ITEM_TARGET = 1950;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
	} sample_pair_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] volume;
		logic [LEVEL_W-1:0] left_level;
		logic [LEVEL_W-1:0] right_level;
		logic               window_done;
	} level_item_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [WIN_W-1:0] cfg_wdata;

	swrm_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) samples_if();
	swrm_level_if levels_if();

	stereo_windowed_rms_meter #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples_if),
		.levels   (levels_if),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// meter state as the block should hold it
	bit [WIN_W-1:0]      win_cfg   = 1;
	bit [63:0]           left_acc  = 0;
	bit [63:0]           right_acc = 0;
	bit [COUNT_BITS-1:0] win_count = 0;
	bit [LEVEL_W-1:0]    left_lvl  = 0;
	bit [LEVEL_W-1:0]    right_lvl = 0;

	sample_pair_t sample_q[$];
	level_item_t  levels_due[$];
	int           mismatches = 0;
	int           item_total = 0;
	int           send_gap   = 0;
	int           recv_gap   = 0;
	int           cycles     = 0;
	bit           idle_on    = 1;

	always #10 clk = ~clk;

	function automatic bit [63:0] square_of(input logic signed [SAMPLE_BITS-1:0] s);
		bit [SAMPLE_BITS-1:0] raw;
		bit [63:0]            m;
		raw = s;
		m = raw[SAMPLE_BITS-1] ? (64'd1 << SAMPLE_BITS) - raw : raw;
		return m * m;
	endfunction

	function automatic bit [63:0] root_floor(input bit [63:0] x);
		bit [63:0] r;
		bit [63:0] c;
		r = 0;
		for (int i = 31; i >= 0; i--) begin
			c = r | (64'd1 << i);
			if (c * c <= x)
				r = c;
		end
		return r;
	endfunction

	function automatic void close_window(input bit [63:0] win);
		left_lvl  = LEVEL_W'(root_floor(left_acc / win));
		right_lvl = LEVEL_W'(root_floor(right_acc / win));
		left_acc  = 0;
		right_acc = 0;
		win_count = 0;
	endfunction

	function automatic level_item_t meter_step(input logic signed [SAMPLE_BITS-1:0] l,
		input logic signed [SAMPLE_BITS-1:0] r);
		bit [63:0]   lsq;
		bit [63:0]   rsq;
		bit [63:0]   win;
		level_item_t res;
		lsq = square_of(l);
		rsq = square_of(r);
		win = (win_cfg == 0) ? 64'd1 : 64'(win_cfg);
		res.window_done = 1'b1;
		if (64'(win_count) >= win) begin
			// shrunken window: old sums close first, this sample opens the next window
			close_window(win);
			left_acc  = lsq;
			right_acc = rsq;
			win_count = 1;
		end else if (64'(win_count) + 1 == win) begin
			left_acc  = left_acc + lsq;
			right_acc = right_acc + rsq;
			close_window(win);
		end else begin
			left_acc  = left_acc + lsq;
			right_acc = right_acc + rsq;
			win_count = win_count + 1'b1;
			res.window_done = 1'b0;
		end
		res.volume      = (left_lvl > right_lvl) ? left_lvl : right_lvl;
		res.left_level  = left_lvl;
		res.right_level = right_lvl;
		return res;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		logic signed [SAMPLE_BITS-1:0] v;
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 4))
					0: v = 16'sh8000;
					1: v = 16'sh7fff;
					2: v = 16'sh0000;
					3: v = -16'sd1;
					default: v = 16'sd1;
				endcase
			end
			1: v = $signed(16'($urandom_range(0, 255))) - 16'sd128;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	task automatic push_pair(input logic signed [SAMPLE_BITS-1:0] l,
		input logic signed [SAMPLE_BITS-1:0] r);
		sample_pair_t p;
		p.left  = l;
		p.right = r;
		sample_q.push_back(p);
		item_total++;
	endtask

	// checked between edges so that the driver and monitor updates have settled
	task automatic wait_drained();
		@(negedge clk);
		while (sample_q.size() != 0 || samples_if.valid || levels_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_window(input logic [WIN_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		win_cfg = v;
	endtask

	// sample driver
	always @(posedge clk) begin : drive_p
		bit           holding;
		sample_pair_t nxt;
		if (!arst_n) begin
			samples_if.valid <= 1'b0;
		end else begin
			if (samples_if.valid && samples_if.ready) begin
				levels_due.push_back(meter_step(samples_if.left_sample, samples_if.right_sample));
				holding = 1'b0;
			end else begin
				holding = samples_if.valid;
			end
			if (!holding) begin
				if (send_gap > 0) begin
					send_gap--;
					samples_if.valid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					nxt = sample_q.pop_front();
					samples_if.valid        <= 1'b1;
					samples_if.left_sample  <= nxt.left;
					samples_if.right_sample <= nxt.right;
					if (idle_on && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 18);
				end else begin
					samples_if.valid <= 1'b0;
				end
			end
		end
	end

	// level monitor
	always @(posedge clk) begin : watch_p
		level_item_t want;
		level_item_t got;
		if (!arst_n) begin
			levels_if.ready <= 1'b0;
		end else begin
			if (levels_if.valid && levels_if.ready) begin
				got.volume      = levels_if.volume;
				got.left_level  = levels_if.left_level;
				got.right_level = levels_if.right_level;
				got.window_done = levels_if.window_done;
				if (levels_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item: volume %0d left %0d right %0d done %0b",
							got.volume, got.left_level, got.right_level, got.window_done);
				end else begin
					want = levels_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected vol %0d l %0d r %0d done %0b, got vol %0d l %0d r %0d done %0b",
								want.volume, want.left_level, want.right_level, want.window_done,
								got.volume, got.left_level, got.right_level, got.window_done);
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				levels_if.ready <= 1'b0;
			end else begin
				levels_if.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 7) == 0)
					recv_gap = $urandom_range(1, 18);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int               n;
		logic [WIN_W-1:0] w;
		clk                     = 1'b0;
		arst_n                  = 1'b1;
		cfg_we                  = 1'b0;
		cfg_wdata               = '0;
		samples_if.valid        = 1'b0;
		samples_if.left_sample  = '0;
		samples_if.right_sample = '0;
		levels_if.ready         = 1'b0;
		#1;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window of one after reset
		push_pair(16'sd0, 16'sd0);
		push_pair(16'sh7fff, 16'sh8000);
		push_pair(16'sh8000, 16'sh7fff);
		push_pair(-16'sd1, 16'sd1);
		wait_drained();

		// zero window acts as one
		write_window(16'd0);
		push_pair(16'sh8000, 16'sh8000);
		push_pair(16'sd1, -16'sd1);
		wait_drained();

		write_window(16'd3);
		push_pair(16'sh7fff, 16'sd0);
		push_pair(16'sh8000, 16'sd100);
		push_pair(-16'sd1, 16'sh8000);
		push_pair(16'sd1234, -16'sd4321);
		push_pair(-16'sd77, 16'sd32000);
		wait_drained();

		// count already at the new window
		write_window(16'd2);
		push_pair(16'sd5, -16'sd5);
		push_pair(16'sd7, 16'sd7);
		wait_drained();

		write_window(16'hffff);
		repeat (8) push_pair(pick_sample(), pick_sample());
		wait_drained();

		write_window(16'd1);
		push_pair(16'sh8000, 16'sh7fff);
		push_pair(16'sd0, -16'sd1);
		wait_drained();

		while (item_total < ITEM_TARGET) begin
			idle_on = (item_total < ITEM_TARGET - 200) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 15))
				0: w = 16'hffff;
				1: w = 16'd1;
				2, 3: w = 16'($urandom_range(13, 300));
				15: w = 16'd0;
				default: w = 16'($urandom_range(1, 12));
			endcase
			write_window(w);
			n = $urandom_range(4, 48);
			repeat (n) push_pair(pick_sample(), pick_sample());
			wait_drained();
		end

		repeat (150) @(posedge clk);
		if (mismatches == 0 && levels_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/swrm_pkg.sv
hw/rtl/swrm_sample_if.sv
hw/rtl/swrm_level_if.sv
hw/rtl/swrm_lane.sv
hw/rtl/stereo_windowed_rms_meter.sv
hw/rtl/swrm_port_checker.sv
sim/tb_top.sv
